FILE: rtl/core/ccpe_pkg.sv
package ccpe_pkg;

  localparam int MAX_TRIPLES_DEF = 31;
  localparam int TRIPLE_W        = 24;
  localparam int COUNT_W         = 5;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic [0:0] REG_ALTERNATE_FIELDS = 1'b0;

  localparam int  CC_VALID_BIT = 2;
  localparam int  PROCESS_BIT  = 6;
  localparam logic [1:0] KIND_FIELD1  = 2'd0;
  localparam logic [1:0] KIND_FIELD2  = 2'd1;
  localparam logic [1:0] KIND_REPEAT  = 2'd2;
  localparam logic [6:0] CTRL_MASK    = 7'h7f;
  localparam logic [6:0] XDS_LOW      = 7'h01;
  localparam logic [6:0] XDS_HIGH     = 7'h0f;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       picture_start;
    logic       scte_source;
  } in_item_t;

  typedef struct packed {
    logic       second_field;
    logic [7:0] first_data;
    logic [7:0] second_data;
    logic       last_of_block;
  } out_item_t;

  typedef enum logic [1:0] {
    PH_HDR,
    PH_EM,
    PH_TRIP
  } phase_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_EVAL,
    ST_FLUSH
  } walk_state_t;

  typedef struct packed {
    logic invert;
    logic previous;
    logic scte;
    logic alternate;
    logic index_odd;
  } fld_ctx_t;

  typedef struct packed {
    logic keep;
    logic field;
    logic invert_nxt;
  } fld_res_t;

endpackage

FILE: rtl/core/ccpe_ram.sv
module ccpe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/core/ccpe_field_unit.sv
module ccpe_field_unit (
  input  logic [ccpe_pkg::TRIPLE_W-1:0] triple,
  input  ccpe_pkg::fld_ctx_t            ctx,
  output ccpe_pkg::fld_res_t            res
);

  logic [7:0] code;
  logic [7:0] d1;
  logic [1:0] kind;
  logic [6:0] d1_low;
  logic       field;
  logic       inv;

  assign code   = triple[23:16];
  assign d1     = triple[15:8];
  assign kind   = code[1:0];
  assign d1_low = d1[6:0] & ccpe_pkg::CTRL_MASK;

  always_comb begin
    field = 1'b0;
    inv   = ctx.invert;
    if (kind == ccpe_pkg::KIND_REPEAT) begin
      field = ~ctx.previous;
      inv   = ~ctx.invert;
    end else begin
      field = (kind ^ {1'b0, ctx.invert}) != 2'd0;
    end
    if (ctx.alternate) begin
      field = ctx.index_odd;
    end
    if (ctx.scte && !field &&
        (d1_low inside {[ccpe_pkg::XDS_LOW:ccpe_pkg::XDS_HIGH]})) begin
      if (kind == ccpe_pkg::KIND_FIELD2) begin
        inv = 1'b0;
      end
      field = 1'b1;
    end
    res.keep       = code[ccpe_pkg::CC_VALID_BIT] &&
                     (ctx.scte || kind == ccpe_pkg::KIND_FIELD1 ||
                      kind == ccpe_pkg::KIND_FIELD2);
    res.field      = field;
    res.invert_nxt = inv;
  end

endmodule

FILE: rtl/core/cc_data_caption_pair_extractor.sv
// cc_data caption pair extractor.
// in_*: one caption user-data byte per item, with picture_start on the first
// byte of a picture and scte_source latched on that byte. Bytes form cc_data
// blocks (header, em byte, count triples). The final byte of a block with the
// process flag set starts a walk over the stored triples: in_ready drops and
// each stored triple is read from the triple RAM (ST_READ, registered read
// port) and then passed through the field unit (ST_EVAL), for up to
// min(count, MAX_TRIPLES) triples.
// out_*: one caption pair per item; last_of_block marks the block's final pair,
// so one kept pair is held back until the next kept pair or the walk end.
// A full result register with out_ready low stalls the walk; input is taken
// again once the walk ends, even while the last pair still waits.
// APB port: register 0 (alternate_fields) at byte address 0.
// Reset (rst_n low, synchronous) clears the parse state, field state, register
// and result valid; triple RAM contents stay undefined until written.
module cc_data_caption_pair_extractor #(
  parameter int MAX_TRIPLES = ccpe_pkg::MAX_TRIPLES_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  ccpe_pkg::in_item_t              in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output ccpe_pkg::out_item_t             out_data,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [ccpe_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [ccpe_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [ccpe_pkg::CFG_DATA_W-1:0] prdata,
  output logic                            pready
);

  localparam int AW = (MAX_TRIPLES > 1) ? $clog2(MAX_TRIPLES) : 1;
  localparam int CW = $clog2(MAX_TRIPLES + 1);
  localparam int CNT_W = ccpe_pkg::COUNT_W;
  localparam int TRIPLE_W_L = ccpe_pkg::TRIPLE_W;

  ccpe_pkg::phase_t      phase_r, phase_nxt;
  ccpe_pkg::walk_state_t state_r, state_nxt;

  logic [CNT_W-1:0] count_r;
  logic             process_r;
  logic [CNT_W-1:0] idx_r;
  logic [1:0]       part_r;
  logic [7:0]       code_r;
  logic [7:0]       d1_r;
  logic             scte_r;
  logic             inv_r;
  logic             prev_r;
  logic             alt_r;
  logic [CW-1:0]    cur_r;
  logic             pend_valid_r;
  ccpe_pkg::out_item_t pend_r;
  logic             out_valid_r;
  ccpe_pkg::out_item_t out_r;

  logic                          in_acc;
  ccpe_pkg::phase_t              eff_phase;
  logic                          last_triple;
  logic                          block_end;
  logic [CW-1:0]                 walk_n;
  logic                          ram_we;
  logic [TRIPLE_W_L-1:0]         ram_rdata;
  logic                          out_free;
  logic                          push;
  logic                          push_last;
  logic                          commit;
  logic                          cfg_wr;
  ccpe_pkg::fld_ctx_t            ctx;
  ccpe_pkg::fld_res_t            res;

  assign in_acc    = in_valid && in_ready;
  assign eff_phase = in_data.picture_start ? ccpe_pkg::PH_HDR : phase_r;
  assign last_triple = (idx_r == count_r - CNT_W'(1));
  assign block_end = in_acc && (eff_phase == ccpe_pkg::PH_TRIP) &&
                     (part_r == 2'd2) && last_triple;
  assign walk_n    = (int'(count_r) > MAX_TRIPLES) ? CW'(MAX_TRIPLES) : CW'(count_r);
  assign out_free  = !out_valid_r || out_ready;
  assign ram_we    = in_acc && (eff_phase == ccpe_pkg::PH_TRIP) && (part_r == 2'd2) &&
                     (int'(idx_r) < MAX_TRIPLES);

  assign cfg_wr = psel && penable && pwrite &&
                  (paddr[ccpe_pkg::CFG_ADDR_W-1:2] == ccpe_pkg::REG_ALTERNATE_FIELDS);
  assign pready = 1'b1;
  assign prdata = (paddr[ccpe_pkg::CFG_ADDR_W-1:2] == ccpe_pkg::REG_ALTERNATE_FIELDS) ?
                  ccpe_pkg::CFG_DATA_W'(alt_r) : '0;

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  ccpe_ram #(
    .WIDTH (TRIPLE_W_L),
    .DEPTH (MAX_TRIPLES)
  ) u_triple_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (AW'(idx_r)),
    .wdata ({code_r, d1_r, in_data.data_byte}),
    .raddr (cur_r[AW-1:0]),
    .rdata (ram_rdata)
  );

  assign ctx.invert    = inv_r;
  assign ctx.previous  = prev_r;
  assign ctx.scte      = scte_r;
  assign ctx.alternate = alt_r;
  assign ctx.index_odd = cur_r[0];

  ccpe_field_unit u_field (
    .triple (ram_rdata),
    .ctx    (ctx),
    .res    (res)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ccpe_pkg::ST_IDLE: begin
        if (block_end && process_r) begin
          state_nxt = ccpe_pkg::ST_READ;
        end
      end
      ccpe_pkg::ST_READ: begin
        state_nxt = (cur_r < walk_n) ? ccpe_pkg::ST_EVAL : ccpe_pkg::ST_FLUSH;
      end
      ccpe_pkg::ST_EVAL: begin
        if (commit) begin
          state_nxt = ccpe_pkg::ST_READ;
        end
      end
      ccpe_pkg::ST_FLUSH: begin
        if (!pend_valid_r || out_free) begin
          state_nxt = ccpe_pkg::ST_IDLE;
        end
      end
      default: state_nxt = ccpe_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = 1'b0;
    push      = 1'b0;
    push_last = 1'b0;
    commit    = 1'b0;
    case (state_r)
      ccpe_pkg::ST_IDLE: begin
        in_ready = 1'b1;
      end
      ccpe_pkg::ST_EVAL: begin
        commit = !(res.keep && pend_valid_r && !out_free);
        push   = res.keep && pend_valid_r && out_free;
      end
      ccpe_pkg::ST_FLUSH: begin
        push      = pend_valid_r && out_free;
        push_last = 1'b1;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  always_comb begin
    phase_nxt = phase_r;
    if (in_acc) begin
      case (eff_phase)
        ccpe_pkg::PH_HDR:  phase_nxt = ccpe_pkg::PH_EM;
        ccpe_pkg::PH_EM:   phase_nxt = (count_r == '0) ? ccpe_pkg::PH_HDR : ccpe_pkg::PH_TRIP;
        ccpe_pkg::PH_TRIP: phase_nxt = block_end ? ccpe_pkg::PH_HDR : ccpe_pkg::PH_TRIP;
        default:           phase_nxt = ccpe_pkg::PH_HDR;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= ccpe_pkg::PH_HDR;
      state_r      <= ccpe_pkg::ST_IDLE;
      count_r      <= '0;
      process_r    <= 1'b0;
      idx_r        <= '0;
      part_r       <= '0;
      scte_r       <= 1'b0;
      inv_r        <= 1'b0;
      prev_r       <= 1'b0;
      alt_r        <= 1'b0;
      cur_r        <= '0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      state_r <= state_nxt;

      if (cfg_wr) begin
        alt_r <= pwdata[0];
      end

      if (in_acc) begin
        if (in_data.picture_start) begin
          scte_r <= in_data.scte_source;
        end
        case (eff_phase)
          ccpe_pkg::PH_HDR: begin
            count_r   <= in_data.data_byte[CNT_W-1:0];
            process_r <= in_data.data_byte[ccpe_pkg::PROCESS_BIT];
          end
          ccpe_pkg::PH_EM: begin
            idx_r  <= '0;
            part_r <= '0;
          end
          ccpe_pkg::PH_TRIP: begin
            if (part_r == 2'd2) begin
              part_r <= '0;
              idx_r  <= idx_r + CNT_W'(1);
            end else begin
              part_r <= part_r + 2'd1;
            end
          end
          default: begin
            part_r <= '0;
          end
        endcase
      end

      if (block_end && process_r) begin
        cur_r <= '0;
      end

      if (state_r == ccpe_pkg::ST_EVAL && commit) begin
        cur_r <= cur_r + CW'(1);
        if (res.keep) begin
          inv_r        <= res.invert_nxt;
          prev_r       <= res.field;
          pend_valid_r <= 1'b1;
        end
      end
      if (state_r == ccpe_pkg::ST_FLUSH && push) begin
        pend_valid_r <= 1'b0;
      end

      if (push) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && eff_phase == ccpe_pkg::PH_TRIP) begin
      if (part_r == 2'd0) begin
        code_r <= in_data.data_byte;
      end
      if (part_r == 2'd1) begin
        d1_r <= in_data.data_byte;
      end
    end
    if (state_r == ccpe_pkg::ST_EVAL && commit && res.keep) begin
      pend_r.second_field  <= res.field;
      pend_r.first_data    <= ram_rdata[15:8];
      pend_r.second_data   <= ram_rdata[7:0];
      pend_r.last_of_block <= 1'b0;
    end
    if (push) begin
      out_r <= '{pend_r.second_field, pend_r.first_data, pend_r.second_data, push_last};
    end
  end

  a_idle_no_pending: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ccpe_pkg::ST_IDLE) |-> !pend_valid_r)
    else $error("pending pair left after walk");

  a_push_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> out_free)
    else $error("result register overwritten");

  a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ccpe_pkg::ST_EVAL) |-> (cur_r < walk_n))
    else $error("walk past stored triples");

  a_no_write_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == ccpe_pkg::ST_IDLE))
    else $error("triple write during walk");

endmodule
